@@ src/ltc_tbl_pkg.sv @@
// Shared constants, types and functions of the bilinear table lookup block.
package ltc_tbl_pkg;

  localparam int GRID_SIZE   = 64;
  localparam int IDX_W       = $clog2(GRID_SIZE);
  localparam int ENTRY_COUNT = 4096;
  localparam int ENTRY_W     = $clog2(ENTRY_COUNT);
  localparam int WORDS       = 10;
  localparam int SEL_W       = 4;
  localparam int COPIES      = 4;
  localparam int SQ_N        = 16;
  localparam int SUM_W       = 50;
  localparam logic [29:0] TWO_OVER_PI_Q30 = 30'd683565276;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Stored word that feeds each output field, in output order.
  localparam int OUT_WORD [WORDS] = '{0, 3, 6, 1, 4, 7, 2, 5, 8, 9};

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [16:0]      w;
  } split_t;

  typedef struct packed {
    logic        action;
    logic        neg;
    logic [11:0] entry;
    logic [3:0]  sel;
    logic [31:0] value;
    logic [44:0] tprod;
  } pipe_t;

  // Clamp floor and ceil of a Q.16 position to the grid and derive the weight.
  function automatic split_t split_pos(input logic [31:0] pos);
    logic [15:0] fl;
    logic [15:0] ce;
    logic [15:0] top;
    logic [15:0] l;
    logic [15:0] h;
    split_t      r;
    fl  = pos[31:16];
    ce  = fl + 16'(pos[15:0] != 16'd0);
    top = 16'(GRID_SIZE - 1);
    l   = (fl > top) ? top : fl;
    h   = (ce > top) ? top : ce;
    r.lo = l[IDX_W-1:0];
    r.hi = h[IDX_W-1:0];
    r.w  = (l == h) ? ONE_Q16 : {1'b0, pos[15:0]};
    return r;
  endfunction

  // Round half up at bit 16 and saturate to the signed 32-bit range.
  function automatic logic [31:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] q;
    logic [31:0]             r;
    t = v + SUM_W'(32768);
    q = t >>> 16;
    if (q > SUM_W'(64'sd2147483647)) begin
      r = 32'h7FFF_FFFF;
    end else if (q < -SUM_W'(64'sd2147483648)) begin
      r = 32'h8000_0000;
    end else begin
      r = q[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/ltc_table_bilinear_lookup_top.sv @@
// Top level of the bilinear grid lookup: sqrt pipeline, grid RAMs and blend stages.
//
// Requests enter on the s_axis channel. tuser is the action: a write stores one
// Q16.16 word of a grid entry, a lookup blends the four grid entries around an
// angle and roughness position. Writes give no result; each lookup gives one
// result on m_axis: the transposed matrix and the amplitude, all Q16.16.
// One request is taken per cycle while s_axis_tready is high. A lookup request
// passes through a one-bit-per-stage square root, the grid RAM read, two
// multiply stages and the output register.
// The grid is held in four copies of ten 4096 x 32 RAMs so that all four
// corners are read together; a write goes to every copy. Writes travel down
// the pipeline and reach the RAMs at the read stage, so the request order holds.
// Grid contents are undefined after reset until written; reset only empties the
// pipeline and the output registers, and there is no clearing pass.
// When the receiver stalls, a result waits in the output register and one more
// lands in a skid register; only when the skid register is full does s_axis
// drop tready and the whole pipeline hold.
module ltc_table_bilinear_lookup_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[11:0], word_select[15:12], word_value[47:16],
  // theta_angle[63:48], alpha_value[79:64]
  input  logic [79:0]  s_axis_tdata,
  // action
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2,
  // amplitude_out, 32 bits each from the lowest bits up
  output logic [319:0] m_axis_tdata
);

  localparam int NS = ltc_tbl_pkg::SQ_N;

  logic advance;
  logic skid_v_q;
  logic out_v_q;
  logic [319:0] out_q;
  logic [319:0] skid_q;

  logic                pv_q   [NS+1];
  ltc_tbl_pkg::pipe_t  pl_q   [NS+1];
  logic [30:0]         rem_q  [NS+1];
  logic [15:0]         root_q [NS+1];
  logic [30:0]         rem_d  [NS];
  logic [15:0]         root_d [NS];

  assign advance       = !skid_v_q;
  assign s_axis_tready = advance;

  // Square root, one result bit per stage.
  always_comb begin
    logic [31:0] trial;
    for (int k = 0; k < NS; k++) begin
      trial = (32'(root_q[k]) << (NS - k)) + (32'd1 << (2 * (NS - 1 - k)));
      if (32'(rem_q[k]) >= trial) begin
        rem_d[k]  = 31'(32'(rem_q[k]) - trial);
        root_d[k] = root_q[k] | (16'd1 << (NS - 1 - k));
      end else begin
        rem_d[k]  = rem_q[k];
        root_d[k] = root_q[k];
      end
    end
  end

  // Positions, indices and RAM addresses at the last sqrt stage.
  logic [16:0]  s_round;
  logic [55:0]  t_wide;
  logic [31:0]  tpos;
  logic [31:0]  apos;
  ltc_tbl_pkg::split_t sp_t;
  ltc_tbl_pkg::split_t sp_a;
  logic [ltc_tbl_pkg::ENTRY_W-1:0] rd_addr [ltc_tbl_pkg::COPIES];
  logic [ltc_tbl_pkg::ENTRY_W-1:0] ram_addr [ltc_tbl_pkg::COPIES];
  logic wr_en;

  always_comb begin
    logic [31:0] sum;
    s_round = {1'b0, root_q[NS]} + 17'(32'(rem_q[NS]) > 32'(root_q[NS]));
    t_wide  = 56'(pl_q[NS].tprod) * 56'(ltc_tbl_pkg::GRID_SIZE) + (56'd1 << 27);
    tpos    = 32'(t_wide[55:28]);
    apos    = 32'(s_round) * 32'(2 * ltc_tbl_pkg::GRID_SIZE);
    sp_t    = ltc_tbl_pkg::split_pos(tpos);
    sp_a    = ltc_tbl_pkg::split_pos(apos);
    for (int c = 0; c < ltc_tbl_pkg::COPIES; c++) begin
      sum = 32'((c % 2 == 1) ? sp_a.hi : sp_a.lo)
          + 32'((c >= 2) ? sp_t.hi : sp_t.lo) * 32'(ltc_tbl_pkg::GRID_SIZE);
      rd_addr[c]  = sum[ltc_tbl_pkg::ENTRY_W-1:0];
      ram_addr[c] = (pl_q[NS].action == ltc_tbl_pkg::ACT_WRITE) ?
                    pl_q[NS].entry[ltc_tbl_pkg::ENTRY_W-1:0] : rd_addr[c];
    end
    wr_en = advance && pv_q[NS] && (pl_q[NS].action == ltc_tbl_pkg::ACT_WRITE)
         && (pl_q[NS].sel < ltc_tbl_pkg::SEL_W'(ltc_tbl_pkg::WORDS));
  end

  logic [31:0] rd_data [ltc_tbl_pkg::COPIES][ltc_tbl_pkg::WORDS];

  for (genvar c = 0; c < ltc_tbl_pkg::COPIES; c++) begin : g_copy
    for (genvar w = 0; w < ltc_tbl_pkg::WORDS; w++) begin : g_word
      ltc_tbl_ram #(
        .WIDTH(32),
        .DEPTH(ltc_tbl_pkg::ENTRY_COUNT)
      ) u_ram (
        .clk_i   (clk_i),
        .en_i    (advance),
        .we_i    (wr_en && (pl_q[NS].sel == ltc_tbl_pkg::SEL_W'(w))),
        .addr_i  (ram_addr[c]),
        .wdata_i (pl_q[NS].value),
        .rdata_o (rd_data[c][w])
      );
    end
  end

  // Stage 17 travels with the RAM read data.
  logic        v17_q, v18_q, v19_q;
  logic        lk17_q, lk18_q, lk19_q;
  logic        neg17_q, neg18_q, neg19_q;
  logic [16:0] wa17_q, wt17_q, wt18_q;
  logic signed [ltc_tbl_pkg::SUM_W-1:0] in_lo_q [ltc_tbl_pkg::WORDS];
  logic signed [ltc_tbl_pkg::SUM_W-1:0] in_hi_q [ltc_tbl_pkg::WORDS];
  logic signed [ltc_tbl_pkg::SUM_W-1:0] outer_q [ltc_tbl_pkg::WORDS];
  logic signed [ltc_tbl_pkg::SUM_W-1:0] in_lo_d [ltc_tbl_pkg::WORDS];
  logic signed [ltc_tbl_pkg::SUM_W-1:0] in_hi_d [ltc_tbl_pkg::WORDS];
  logic signed [ltc_tbl_pkg::SUM_W-1:0] outer_d [ltc_tbl_pkg::WORDS];
  logic [319:0] res;

  always_comb begin
    logic signed [17:0] wa_s, wa_n, wt_s, wt_n;
    logic signed [31:0] rlo, rhi;
    wa_s = $signed({1'b0, wa17_q});
    wa_n = $signed({1'b0, ltc_tbl_pkg::ONE_Q16 - wa17_q});
    wt_s = $signed({1'b0, wt18_q});
    wt_n = $signed({1'b0, ltc_tbl_pkg::ONE_Q16 - wt18_q});
    for (int w = 0; w < ltc_tbl_pkg::WORDS; w++) begin
      in_lo_d[w] = wa_n * $signed(rd_data[0][w]) + wa_s * $signed(rd_data[1][w]);
      in_hi_d[w] = wa_n * $signed(rd_data[2][w]) + wa_s * $signed(rd_data[3][w]);
      rlo = $signed(ltc_tbl_pkg::round_sat(in_lo_q[w]));
      rhi = $signed(ltc_tbl_pkg::round_sat(in_hi_q[w]));
      outer_d[w] = wt_n * rlo + wt_s * rhi;
    end
    for (int j = 0; j < ltc_tbl_pkg::WORDS; j++) begin
      res[32*j +: 32] = neg19_q ? 32'd0
                      : ltc_tbl_pkg::round_sat(outer_q[ltc_tbl_pkg::OUT_WORD[j]]);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) begin
        pv_q[k] <= 1'b0;
      end
      v17_q    <= 1'b0;
      v18_q    <= 1'b0;
      v19_q    <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (advance) begin
        pv_q[0] <= s_axis_tvalid;
        for (int k = 0; k < NS; k++) begin
          pv_q[k+1] <= pv_q[k];
        end
        v17_q <= pv_q[NS];
        v18_q <= v17_q;
        v19_q <= v18_q;
      end
      if (!out_v_q || m_axis_tready) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= v19_q && lk19_q;
        end
      end else if (advance && v19_q && lk19_q) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pl_q[0].action <= s_axis_tuser;
      pl_q[0].neg    <= s_axis_tdata[63];
      pl_q[0].entry  <= s_axis_tdata[11:0];
      pl_q[0].sel    <= s_axis_tdata[15:12];
      pl_q[0].value  <= s_axis_tdata[47:16];
      pl_q[0].tprod  <= 45'(s_axis_tdata[62:48]) * 45'(ltc_tbl_pkg::TWO_OVER_PI_Q30);
      rem_q[0]       <= {s_axis_tdata[79:64], 15'd0};
      root_q[0]      <= 16'd0;
      for (int k = 0; k < NS; k++) begin
        pl_q[k+1]   <= pl_q[k];
        rem_q[k+1]  <= rem_d[k];
        root_q[k+1] <= root_d[k];
      end
      lk17_q  <= pl_q[NS].action == ltc_tbl_pkg::ACT_LOOKUP;
      neg17_q <= pl_q[NS].neg;
      wa17_q  <= sp_a.w;
      wt17_q  <= sp_t.w;
      lk18_q  <= lk17_q;
      neg18_q <= neg17_q;
      wt18_q  <= wt17_q;
      lk19_q  <= lk18_q;
      neg19_q <= neg18_q;
      for (int w = 0; w < ltc_tbl_pkg::WORDS; w++) begin
        in_lo_q[w] <= in_lo_d[w];
        in_hi_q[w] <= in_hi_d[w];
        outer_q[w] <= outer_d[w];
      end
    end
    if (!out_v_q || m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (advance && v19_q && lk19_q) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !m_axis_tready |=> skid_v_q)
    else $error("waiting result lost from skid register");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
    else $error("skid register filled while output was free");

endmodule

@@ src/ltc_tbl_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module ltc_tbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
